// ===== sv/dq_pkg.sv =====
// dq_pkg: operation, status and state codes plus default sizes for the
// double-ended queue. No dependencies.
`default_nettype none

package dq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      FUNC_PUSH_BACK  = 2'd0,
      FUNC_PUSH_FRONT = 2'd1,
      FUNC_POP_BACK   = 2'd2,
      FUNC_POP_FRONT  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      STATE_IDLE  = 1'b0,
      STATE_FETCH = 1'b1
   } state_type;

endpackage

`default_nettype wire

// ===== sv/double_ended_queue_top.sv =====
// double_ended_queue_top: bounded deque kept as a ring in one synchronous memory,
// with the front and rear entries cached in registers. Depends on dq_pkg.
//
//   channel   direction  transfer                     payload
//   request   in         start && !busy at clock edge req_func, req_value
//   response  out        rsp_valid for one cycle      rsp_popped_value, rsp_status,
//                                                     rsp_front_value, rsp_rear_value,
//                                                     rsp_occupancy, rsp_is_empty
//
// pushes, failed pops and pops that empty the deque give their result directly: the result
// strobes in the cycle after the transfer and busy stays low.
// a pop that leaves one or more entries goes through the fetch state: the new end entry is
// fetched through the registered memory read port, busy is high meanwhile.
// reset clears the ring pointers and the count; the memory is not cleared.
// results cannot be stalled and are shown for exactly one cycle.
`default_nettype none

module double_ended_queue_top #(
   parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT,
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input  wire  logic                clock,
   input  wire  logic                reset,
   input  wire  logic                start,
   output       logic                busy,
   input  wire  logic [1:0]          req_func,
   input  wire  logic signed [31:0]  req_value,
   output       logic                rsp_valid,
   output       logic signed [31:0]  rsp_popped_value,
   output       logic [1:0]          rsp_status,
   output       logic signed [31:0]  rsp_front_value,
   output       logic signed [31:0]  rsp_rear_value,
   output       logic [CNT_W-1:0]    rsp_occupancy,
   output       logic                rsp_is_empty
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   // sign-extend (or truncate) a stored word to the 32-bit result width
   function automatic logic signed [31:0] word_out(input logic [DATA_WIDTH-1:0] w);
      return 32'(signed'(w));
   endfunction

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   dq_pkg::state_type     state_ff, state_in;
   logic [IDX_W-1:0]      front_ff, front_in;
   logic [IDX_W-1:0]      rear_ff, rear_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_WIDTH-1:0] front_val_ff, front_val_in;
   logic [DATA_WIDTH-1:0] rear_val_ff, rear_val_in;
   logic                  pop_back_ff, pop_back_in;
   logic                  valid_ff, valid_in;
   logic signed [31:0]    popped_ff, popped_in;
   dq_pkg::status_type    status_ff, status_in;

   logic                  accept;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [IDX_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] push_word;

   assign busy      = (state_ff == dq_pkg::STATE_FETCH);
   assign accept    = start && !busy;
   assign push_word = DATA_WIDTH'(req_value);

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      rear_in      = rear_ff;
      count_in     = count_ff;
      front_val_in = front_val_ff;
      rear_val_in  = rear_val_ff;
      pop_back_in  = pop_back_ff;
      valid_in     = 1'b0;
      popped_in    = popped_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      wr_addr      = front_ff;
      rd_addr      = front_ff;
      unique case (state_ff)
         dq_pkg::STATE_IDLE: begin
            if (accept) begin
               popped_in = '0;
               status_in = dq_pkg::STATUS_OK;
               unique case (dq_pkg::func_type'(req_func))
                  dq_pkg::FUNC_PUSH_BACK: begin
                     valid_in = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        status_in = dq_pkg::STATUS_OVERFLOW;
                     end else begin
                        wr_en       = 1'b1;
                        wr_addr     = (count_ff == '0) ? front_ff : idx_next(rear_ff);
                        rear_in     = wr_addr;
                        rear_val_in = push_word;
                        if (count_ff == '0) front_val_in = push_word;
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  dq_pkg::FUNC_PUSH_FRONT: begin
                     valid_in = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        status_in = dq_pkg::STATUS_OVERFLOW;
                     end else begin
                        wr_en        = 1'b1;
                        wr_addr      = idx_prev(front_ff);
                        front_in     = wr_addr;
                        front_val_in = push_word;
                        if (count_ff == '0) begin
                           rear_in     = wr_addr;
                           rear_val_in = push_word;
                        end
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  dq_pkg::FUNC_POP_BACK: begin
                     if (count_ff == '0) begin
                        valid_in  = 1'b1;
                        status_in = dq_pkg::STATUS_UNDERFLOW;
                     end else begin
                        popped_in   = word_out(rear_val_ff);
                        rear_in     = idx_prev(rear_ff);
                        rd_addr     = idx_prev(rear_ff);
                        pop_back_in = 1'b1;
                        count_in    = count_ff - 1'b1;
                        // new rear comes back from memory in the next cycle
                        if (count_ff > CNT_W'(1)) state_in = dq_pkg::STATE_FETCH;
                        else valid_in = 1'b1;
                     end
                  end
                  dq_pkg::FUNC_POP_FRONT: begin
                     if (count_ff == '0) begin
                        valid_in  = 1'b1;
                        status_in = dq_pkg::STATUS_UNDERFLOW;
                     end else begin
                        popped_in   = word_out(front_val_ff);
                        front_in    = idx_next(front_ff);
                        rd_addr     = idx_next(front_ff);
                        pop_back_in = 1'b0;
                        count_in    = count_ff - 1'b1;
                        if (count_ff > CNT_W'(1)) state_in = dq_pkg::STATE_FETCH;
                        else valid_in = 1'b1;
                     end
                  end
                  default: begin
                     valid_in = 1'b0;
                  end
               endcase
            end
         end
         dq_pkg::STATE_FETCH: begin
            if (pop_back_ff) rear_val_in = rdata_ff;
            else front_val_in = rdata_ff;
            valid_in = 1'b1;
            state_in = dq_pkg::STATE_IDLE;
         end
         default: begin
            state_in = dq_pkg::STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dq_pkg::STATE_IDLE;
         front_ff <= '0;
         rear_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      front_val_ff <= front_val_in;
      rear_val_ff  <= rear_val_in;
      pop_back_ff  <= pop_back_in;
      popped_ff    <= popped_in;
      status_ff    <= status_in;
   end

   // ring storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= push_word;
      rdata_ff <= mem[rd_addr];
   end

   assign rsp_valid        = valid_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_status       = status_ff;
   assign rsp_occupancy    = count_ff;
   assign rsp_is_empty     = (count_ff == '0);
   assign rsp_front_value  = rsp_is_empty ? '0 : word_out(front_val_ff);
   assign rsp_rear_value   = rsp_is_empty ? '0 : word_out(rear_val_ff);

`ifndef SYNTHESIS
   a_fetch_then_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("fetch cycle did not end in a result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count beyond depth");

   a_single_entry_ends: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(1)) |-> (front_ff == rear_ff))
      else $error("front and rear differ with one entry");

   a_push_result: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_func[1]) |=> (rsp_valid && !busy))
      else $error("push transfer without next-cycle result");

   a_no_write_when_fetching: assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr_en)
      else $error("memory write during fetch");
`endif

endmodule

`default_nettype wire
